// ===== hdl/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin primality tester.
// Holds the sequencer state, the command and status bundles and the base table.
// No dependencies.
`timescale 1ns / 1ps

package mrpt_pkg;

    localparam int NUM_BASES = 6;
    localparam int BASE_BITS = 24;

    typedef logic [2:0] base_idx_t;

    typedef enum logic [1:0] {
        MUL_RED,
        MUL_RES,
        MUL_SQ,
        MUL_X
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASSIFY,
        S_FACTOR,
        S_RED,
        S_RED_WAIT,
        S_POW_STEP,
        S_POW_MWAIT,
        S_POW_SQ,
        S_POW_SWAIT,
        S_CHECK,
        S_LOOP,
        S_LOOP_WAIT,
        S_LOOP_TEST,
        S_NEXT_BASE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    fac_init;
        logic    fac_shift;
        logic    mul_start;
        mul_op_t mul_op;
        logic    pow_init;
        logic    e_shift;
        logic    k_init;
        logic    k_inc;
        logic    base_inc;
    } mr_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_eq2;
        logic n_even;
        logic d_odd;
        logic mul_busy;
        logic mul_done;
        logic prod_zero;
        logic e_lsb;
        logic e_last;
        logic x_one;
        logic x_nm1;
        logic k_lt_r;
        logic base_last;
    } mr_status_t;

    function automatic logic [BASE_BITS-1:0] base_value(input base_idx_t idx);
        logic [BASE_BITS-1:0] v;
        unique case (idx)
            3'd0:    v = 24'd2;
            3'd1:    v = 24'd325;
            3'd2:    v = 24'd9375;
            3'd3:    v = 24'd28178;
            3'd4:    v = 24'd450775;
            3'd5:    v = 24'd9780504;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/miller_rabin_primality_test.sv =====
// Miller-Rabin primality tester, fixed bases 2, 325, 9375, 28178, 450775, 9780504.
// Top level; depends on mrpt_pkg, mrpt_ctrl, mrpt_datapath, mrpt_modmul.
//
// Usage:
//   Input stream s_*: one candidate per transfer, low WIDTH bits are tested.
//   Output stream m_*: one transfer per candidate, m_tdata[0] = 1 for prime.
//   s_tready is high only while the block is idle; one candidate is in work
//   at a time. A finished result sits in the output register, and the next
//   candidate is accepted while it waits to be taken.
// Work: small candidates (below two or even) are settled without any
//   multiply. Odd candidates take roughly 2*WIDTH modular multiplies per
//   base, each run in the bit-serial shift-add multiplier, which sets the
//   overall speed.
// Stall: if the output register is still full and m_tready is low while a new
//   result is ready, the sequencer holds that result until the register drains; no result is lost.
// Reset: rst_n (asynchronous, active low) returns the sequencer to idle
//   and empties the output register.
`timescale 1ns / 1ps

module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [63:0] candidate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // [0] is_prime, [7:1] zero
);

    mr_cmd_t    cmd;
    mr_status_t sts;
    logic       is_prime;

    mrpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .is_prime (is_prime),
        .cmd      (cmd),
        .sts      (sts)
    );

    mrpt_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (s_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tdata = {7'b0, is_prime};

endmodule

// ===== hdl/mrpt_modmul.sv =====
// Bit-serial modular multiplier: (x * y) mod m by shift-and-add, one bit of y per cycle.
// Requires x < m. Uses no package items.
`timescale 1ns / 1ps

module mrpt_modmul #(
    parameter int W  = 64,
    parameter int YW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  x,
    input  logic [YW-1:0] y,
    input  logic [W-1:0]  m,
    output logic          busy,
    output logic          done,
    output logic [W-1:0]  product
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  addend_reg;
    logic [YW-1:0] y_reg;

    // sum kept one bit wider so the carry is never lost
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] md);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, md})
        begin
            s = s - {1'b0, md};
        end
        return s[W-1:0];
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = (y != '0);
            done_next = (y == '0);
        end
        else if (busy_reg && (y_reg[YW-1:1] == '0))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            addend_reg <= x;
            y_reg      <= y;
        end
        else if (busy_reg)
        begin
            if (y_reg[0])
            begin
                acc_reg <= add_mod(acc_reg, addend_reg, m);
            end
            addend_reg <= add_mod(addend_reg, addend_reg, m);
            y_reg      <= y_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

`ifndef NO_ASSERTIONS
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("multiplier busy and done together");

    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (acc_reg < m) && (addend_reg < m))
        else $error("multiplier operand not reduced");
`endif

endmodule

// ===== hdl/mrpt_datapath.sv =====
// Datapath: candidate, n-1 factoring, exponent, running values and base index.
// Depends on mrpt_pkg and mrpt_modmul.
`timescale 1ns / 1ps

module mrpt_datapath
    import mrpt_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] candidate,
    input  mr_cmd_t     cmd,
    output mr_status_t  sts
);

    localparam int YW = (WIDTH > BASE_BITS) ? WIDTH : BASE_BITS;
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] nm1_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    k_reg;
    base_idx_t        idx_reg;
    mul_op_t          op_reg;

    logic [WIDTH-1:0] mul_x;
    logic [YW-1:0]    mul_y;
    logic             mul_busy;
    logic             mul_done;
    logic [WIDTH-1:0] prod;

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_RED:
            begin
                mul_x = WIDTH'(1);
                mul_y = YW'(base_value(idx_reg));
            end
            MUL_RES:
            begin
                mul_x = x_reg;
                mul_y = YW'(sq_reg);
            end
            MUL_SQ:
            begin
                mul_x = sq_reg;
                mul_y = YW'(sq_reg);
            end
            MUL_X:
            begin
                mul_x = x_reg;
                mul_y = YW'(x_reg);
            end
            default:
            begin
                mul_x = x_reg;
                mul_y = YW'(x_reg);
            end
        endcase
    end

    mrpt_modmul #(
        .W  (WIDTH),
        .YW (YW)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (n_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= candidate[WIDTH-1:0];
        end
        if (cmd.fac_init)
        begin
            d_reg   <= n_reg - WIDTH'(1);
            nm1_reg <= n_reg - WIDTH'(1);
            r_reg   <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.fac_shift)
            begin
                d_reg <= d_reg >> 1;
                r_reg <= r_reg + CW'(1);
            end
            if (cmd.base_inc)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
        if (cmd.mul_start)
        begin
            op_reg <= cmd.mul_op;
        end
        if (cmd.pow_init)
        begin
            x_reg  <= WIDTH'(1);
            sq_reg <= prod;
            e_reg  <= d_reg;
        end
        else
        begin
            if (cmd.e_shift)
            begin
                e_reg <= e_reg >> 1;
            end
            if (mul_done)
            begin
                unique case (op_reg)
                    MUL_RES: x_reg  <= prod;
                    MUL_X:   x_reg  <= prod;
                    MUL_SQ:  sq_reg <= prod;
                    MUL_RED: ;
                    default: ;
                endcase
            end
        end
        if (cmd.k_init)
        begin
            k_reg <= CW'(1);
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + CW'(1);
        end
    end

    always_comb
    begin
        sts.n_lt2     = (n_reg[WIDTH-1:1] == '0);
        sts.n_eq2     = (n_reg == WIDTH'(2));
        sts.n_even    = !n_reg[0];
        sts.d_odd     = d_reg[0];
        sts.mul_busy  = mul_busy;
        sts.mul_done  = mul_done;
        sts.prod_zero = (prod == '0);
        sts.e_lsb     = e_reg[0];
        sts.e_last    = (e_reg[WIDTH-1:1] == '0);
        sts.x_one     = (x_reg == WIDTH'(1));
        sts.x_nm1     = (x_reg == nm1_reg);
        sts.k_lt_r    = (k_reg < r_reg);
        sts.base_last = (idx_reg == 3'(NUM_BASES - 1));
    end

endmodule

// ===== hdl/mrpt_ctrl.sv =====
// Sequencer for the Miller-Rabin test plus the input handshake and output register.
// Depends on mrpt_pkg.
`timescale 1ns / 1ps

module mrpt_ctrl
    import mrpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       is_prime,
    output mr_cmd_t    cmd,
    input  mr_status_t sts
);

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_prime_reg, is_prime_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            is_prime_reg  <= is_prime_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        is_prime_next  = is_prime_reg;
        cmd            = '0;
        cmd.mul_op     = MUL_RED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (sts.n_lt2)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (sts.n_eq2)
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.n_even)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.fac_init = 1'b1;
                    state_next   = S_FACTOR;
                end
            end
            S_FACTOR:
            begin
                if (sts.d_odd)
                begin
                    state_next = S_RED;
                end
                else
                begin
                    cmd.fac_shift = 1'b1;
                end
            end
            S_RED:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MUL_RED;
                state_next    = S_RED_WAIT;
            end
            S_RED_WAIT:
            begin
                if (sts.mul_done)
                begin
                    if (sts.prod_zero)
                    begin
                        state_next = S_NEXT_BASE;
                    end
                    else
                    begin
                        cmd.pow_init = 1'b1;
                        state_next   = S_POW_STEP;
                    end
                end
            end
            S_POW_STEP:
            begin
                if (sts.e_lsb)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_RES;
                    state_next    = S_POW_MWAIT;
                end
                else
                begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ:
            begin
                if (sts.e_last)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_SQ;
                    cmd.e_shift   = 1'b1;
                    state_next    = S_POW_SWAIT;
                end
            end
            S_POW_SWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_POW_STEP;
                end
            end
            S_CHECK:
            begin
                if (sts.x_one || sts.x_nm1)
                begin
                    state_next = S_NEXT_BASE;
                end
                else
                begin
                    cmd.k_init = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (!sts.k_lt_r)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = MUL_X;
                    state_next    = S_LOOP_WAIT;
                end
            end
            S_LOOP_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_LOOP_TEST;
                end
            end
            S_LOOP_TEST:
            begin
                if (sts.x_nm1)
                begin
                    state_next = S_NEXT_BASE;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_NEXT_BASE:
            begin
                if (sts.base_last)
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.base_inc = 1'b1;
                    state_next   = S_RED;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign is_prime = is_prime_reg;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.mul_busy)
        else $error("multiply started while busy");

    a_wait_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED_WAIT || state_reg == S_POW_MWAIT || state_reg == S_POW_SWAIT
         || state_reg == S_LOOP_WAIT) |-> (sts.mul_busy || sts.mul_done))
        else $error("waiting on an idle multiplier");

    a_two_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLASSIFY && sts.n_eq2) |=> (res_reg && state_reg == S_DONE))
        else $error("two not reported prime");
`endif

endmodule

// ===== sim/mrpt_verdict_monitor.sv =====
// Watches both streams of the Miller-Rabin tester, predicts each verdict and compares.
// Stand-alone; uses 128-bit products for the modular arithmetic, no RTL functions.
`timescale 1ns / 1ps

module mrpt_verdict_monitor #(
    parameter int WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          mismatch_count,
    output int          verdicts_outstanding
);

    typedef struct packed {
        logic [63:0] candidate;
        logic        is_prime;
    } verdict_t;

    verdict_t expected_verdicts[$];
    int       fails = 0;

    function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        p = p % {64'd0, m};
        return p[63:0];
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mulmod(acc, sq, m);
            sq = mulmod(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic passes_fixed_bases(input logic [63:0] raw);
        logic [63:0] n;
        logic [63:0] nm1;
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] witness;
        int          r;
        int          k;
        logic        hit;
        n = raw;
        if (WIDTH < 64)
            n = n & ((64'd1 << WIDTH) - 64'd1);
        if (n < 64'd2)
            return 1'b0;
        if (n == 64'd2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        nm1 = n - 64'd1;
        d   = nm1;
        r   = 0;
        while (!d[0])
        begin
            d = d >> 1;
            r++;
        end
        for (int i = 0; i < 6; i++)
        begin
            unique case (i)
                0:       witness = 64'd2;
                1:       witness = 64'd325;
                2:       witness = 64'd9375;
                3:       witness = 64'd28178;
                4:       witness = 64'd450775;
                default: witness = 64'd9780504;
            endcase
            a = witness % n;
            if (a == 0)
                continue;
            x = powmod(a, d, n);
            if (x == 64'd1 || x == nm1)
                continue;
            hit = 1'b0;
            for (k = 1; k < r; k++)
            begin
                x = mulmod(x, x, n);
                if (x == nm1)
                begin
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        verdict_t head;
        verdict_t entry;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fails++;
                    $display("%0t: result is_prime=%0b with no candidate outstanding",
                             $time, m_tdata[0]);
                end
                else
                begin
                    head = expected_verdicts.pop_front();
                    if (m_tdata[0] !== head.is_prime)
                    begin
                        fails++;
                        $display("%0t: candidate %0d expected is_prime=%0b, got %0b",
                                 $time, head.candidate, head.is_prime, m_tdata[0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                entry.candidate = s_tdata;
                entry.is_prime  = passes_fixed_bases(s_tdata);
                expected_verdicts.push_back(entry);
            end
        end
        mismatch_count       <= fails;
        verdicts_outstanding <= expected_verdicts.size();
    end

endmodule

// ===== sim/miller_rabin_primality_test_tb.sv =====
// Stimulus and verdict for the Miller-Rabin primality tester.
// Depends on miller_rabin_primality_test (and its package) and mrpt_verdict_monitor.
`timescale 1ns / 1ps

module miller_rabin_primality_test_tb;

    localparam int WIDTH        = 64;
    localparam int STALL_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int PHASE_ITEMS  = 18;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] candidate
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] is_prime, [7:1] zero

    int   mismatch_count;
    int   verdicts_outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_request;
    logic hold_taken;
    int   quiet_cycles;

    miller_rabin_primality_test #(
        .WIDTH(WIDTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    mrpt_verdict_monitor #(
        .WIDTH(WIDTH)
    ) u_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .mismatch_count(mismatch_count),
        .verdicts_outstanding(verdicts_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        m_tready   <= 1'b0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("miller_rabin_primality_test: mismatch");
                $finish;
            end
        end
    end

    task automatic offer_candidate(input logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_outstanding != 0)
            @(posedge clk);
    endtask

    // mostly small odd candidates keep the multiplies short; a few reach full width
    function automatic logic [63:0] random_candidate();
        logic [63:0] value;
        int          sel;
        int          bits;
        sel   = $urandom_range(99);
        value = {$urandom(), $urandom()};
        if (sel < 3)
            return value;
        if (sel < 13)
        begin
            bits  = $urandom_range(36, 17);
            value = value & ((64'd1 << bits) - 64'd1);
            value[bits-1] = 1'b1;
            value[0]      = 1'b1;
            return value;
        end
        if (sel < 20)
            return 64'($urandom_range(16));
        bits  = $urandom_range(16, 3);
        value = value & ((64'd1 << bits) - 64'd1);
        if ($urandom_range(99) < 70)
            value[0] = 1'b1;
        return value;
    endfunction

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 64'd0;
        hold_request   <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // below two, two itself, small primes and composites
        offer_candidate(64'd0);
        offer_candidate(64'd1);
        offer_candidate(64'd2);
        offer_candidate(64'd3);
        offer_candidate(64'd4);
        offer_candidate(64'd5);
        offer_candidate(64'd7);
        offer_candidate(64'd9);
        offer_candidate(64'd13);
        offer_candidate(64'd25);
        // pseudoprimes and candidates that divide a base
        offer_candidate(64'd341);
        offer_candidate(64'd561);
        offer_candidate(64'd2047);
        offer_candidate(64'd65537);
        offer_candidate(64'd450775);
        offer_candidate(64'd9780504);
        offer_candidate(64'd3215031751);
        offer_candidate(64'h0000_0001_0000_0001);
        // full-width corners
        offer_candidate(64'h1FFF_FFFF_FFFF_FFFF);
        offer_candidate(64'h8000_0000_0000_0000);
        offer_candidate(64'h8000_0000_0000_0001);
        offer_candidate(64'd18446744073709551557);
        offer_candidate(64'hFFFF_FFFF_FFFF_FFFE);
        offer_candidate(64'hFFFF_FFFF_FFFF_FFFF);
        wait_for_verdicts();

        // long receiver hold-off while candidates keep coming
        hold_request <= 1'b1;
        offer_candidate(64'd8);
        offer_candidate(64'd21);
        offer_candidate(64'd23);
        offer_candidate(64'd100);
        offer_candidate(64'd97);
        offer_candidate(64'd1);
        wait_for_verdicts();

        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_candidate(random_candidate());
        end

        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("miller_rabin_primality_test: match");
        else
            $display("miller_rabin_primality_test: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mrpt_pkg.sv
hdl/mrpt_modmul.sv
hdl/mrpt_datapath.sv
hdl/mrpt_ctrl.sv
hdl/miller_rabin_primality_test.sv
sim/mrpt_verdict_monitor.sv
sim/miller_rabin_primality_test_tb.sv
